FILE: hw/rtl/rsp_pkg.sv
package rsp_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_HDR_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE  = 3'd2;
  localparam logic [2:0] ST_CSUM_ERR    = 3'd3;
  localparam logic [2:0] ST_RANGE_ERR   = 3'd4;

  // frame constants
  localparam logic [7:0]  HDR_BYTE = 8'hFF;
  localparam logic [15:0] MIN_MM   = 16'd30;
  localparam logic [15:0] MAX_MM   = 16'd4500;

  // register map
  localparam int unsigned   ADDR_W           = 3;
  localparam logic          REG_WAIT_TICKS   = 1'b0;
  localparam logic [15:0]   WAIT_TICKS_RESET = 16'd100;

  localparam int unsigned DIST_W = 13;
  localparam int unsigned STAT_W = 3;

  typedef struct packed {
    logic [DIST_W-1:0] range_mm;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_push_t;

endpackage

FILE: hw/rtl/rsp_frame_fsm.sv
module rsp_frame_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_accept,
  input  logic [1:0]           command,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          wait_ticks,
  output rsp_pkg::result_push_t push
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HUNT    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bytes_taken_r, bytes_taken_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  dist_hi_r, dist_hi_nxt;
  logic [7:0]  dist_lo_r, dist_lo_nxt;

  logic [16:0] tick_next;
  logic [7:0]  csum;
  logic [15:0] dist_full;

  assign tick_next = {1'b0, elapsed_r} + 17'd1;
  assign csum      = rsp_pkg::HDR_BYTE + dist_hi_r + dist_lo_r;
  assign dist_full = {dist_hi_r, dist_lo_r};

  always_comb begin
    phase_nxt       = phase_r;
    bytes_taken_nxt = bytes_taken_r;
    elapsed_nxt     = elapsed_r;
    dist_hi_nxt     = dist_hi_r;
    dist_lo_nxt     = dist_lo_r;
    push.valid            = 1'b0;
    push.data.range_mm    = '0;
    push.data.status      = rsp_pkg::ST_OK;

    if (item_accept) begin
      unique case (command)
        rsp_pkg::CMD_START: begin
          phase_nxt       = PH_HUNT;
          bytes_taken_nxt = 2'd0;
          elapsed_nxt     = 16'd0;
        end
        rsp_pkg::CMD_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (tick_next >= {1'b0, wait_ticks}) begin
              push.valid       = 1'b1;
              push.data.status = (phase_r == PH_HUNT) ? rsp_pkg::ST_HDR_TIMEOUT
                                                      : rsp_pkg::ST_INCOMPLETE;
              phase_nxt        = PH_IDLE;
              bytes_taken_nxt  = 2'd0;
              elapsed_nxt      = 16'd0;
            end else begin
              elapsed_nxt = tick_next[15:0];
            end
          end
        end
        rsp_pkg::CMD_BYTE: begin
          if (phase_r == PH_HUNT) begin
            if (rx_byte == rsp_pkg::HDR_BYTE) begin
              phase_nxt       = PH_COLLECT;
              bytes_taken_nxt = 2'd0;
              elapsed_nxt     = 16'd0;
            end
          end else if (phase_r == PH_COLLECT) begin
            unique case (bytes_taken_r)
              2'd0: begin
                dist_hi_nxt     = rx_byte;
                bytes_taken_nxt = 2'd1;
              end
              2'd1: begin
                dist_lo_nxt     = rx_byte;
                bytes_taken_nxt = 2'd2;
              end
              default: begin
                // checksum byte closes the frame
                push.valid      = 1'b1;
                phase_nxt       = PH_IDLE;
                bytes_taken_nxt = 2'd0;
                elapsed_nxt     = 16'd0;
                if (csum != rx_byte) begin
                  push.data.status = rsp_pkg::ST_CSUM_ERR;
                end else if (dist_full < rsp_pkg::MIN_MM || dist_full > rsp_pkg::MAX_MM) begin
                  push.data.status = rsp_pkg::ST_RANGE_ERR;
                end else begin
                  push.data.range_mm = dist_full[rsp_pkg::DIST_W-1:0];
                end
              end
            endcase
          end
        end
        default: begin
          // unused command, nothing changes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_taken_r <= 2'd0;
      elapsed_r     <= 16'd0;
      dist_hi_r     <= 8'd0;
      dist_lo_r     <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      bytes_taken_r <= bytes_taken_nxt;
      elapsed_r     <= elapsed_nxt;
      dist_hi_r     <= dist_hi_nxt;
      dist_lo_r     <= dist_lo_nxt;
    end
  end

endmodule

FILE: hw/rtl/rsp_out_buf.sv
module rsp_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsp_pkg::result_push_t push,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsp_pkg::result_t      out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  rsp_pkg::result_t main_data_r, main_data_nxt;
  rsp_pkg::result_t skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_data_nxt  = main_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        // skid full means no push this cycle
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push.valid) begin
        main_data_nxt = push.data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = push.data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

FILE: hw/rtl/ranging_sensor_packet_parser_core.sv
// ranging sensor packet parser
// input channel (in_valid/in_ready): one item is a command, plus a serial
//   byte for the byte command; start arms a hunt for the 0xff header, bytes
//   then fill high, low and checksum, ticks count time for the timeouts
// result channel (out_valid/out_ready): one item per finished measurement,
//   distance in mm and a status code (ok, header timeout, incomplete,
//   checksum mismatch, out of range)
// config: apb-style port, wait_ticks at byte address 0, pready tied high
// result path: the result of the item that closes the measurement is written
//   into the result register, or into the skid entry while that one is held
// throughput: one item per cycle while in_ready is high; frame state is
//   updated in one pass of logic between state and result registers
// stall: a two-entry output buffer (result register plus skid) keeps
//   in_ready high while one result waits; in_ready drops only when both
//   entries are full and then returns the cycle after out_ready is seen
// reset: synchronous active-low, parser goes idle, output buffer empties,
//   wait_ticks returns to 100
module ranging_sensor_packet_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsp_pkg::DIST_W-1:0]    out_range_mm,
  output logic [rsp_pkg::STAT_W-1:0]    out_status,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsp_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                  item_accept;
  logic                  buf_space;
  logic                  cfg_wr;
  logic [15:0]           wait_ticks_r;
  rsp_pkg::result_push_t push;
  rsp_pkg::result_t      out_data;

  // a register beyond the list (paddr bit 2 set) is ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rsp_pkg::REG_WAIT_TICKS);
  assign prdata = (paddr[2] == rsp_pkg::REG_WAIT_TICKS) ? {16'd0, wait_ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= rsp_pkg::WAIT_TICKS_RESET;
    end else if (cfg_wr) begin
      wait_ticks_r <= pwdata[15:0];
    end
  end

  // accept whenever the output buffer can still hold a result
  assign in_ready    = buf_space;
  assign item_accept = in_valid && in_ready;

  rsp_frame_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (item_accept),
    .command     (in_command),
    .rx_byte     (in_rx_byte),
    .wait_ticks  (wait_ticks_r),
    .push        (push)
  );

  rsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (buf_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_range_mm = out_data.range_mm;
  assign out_status   = out_data.status;

endmodule

FILE: hw/rtl/rsp_checker.sv
module rsp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rsp_pkg::DIST_W-1:0] out_range_mm,
  input logic [rsp_pkg::STAT_W-1:0] out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_mm) && $stable(out_status))
    else $error("result changed while stalled");

  // distance only on ok
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rsp_pkg::ST_OK |-> out_range_mm == '0)
    else $error("nonzero distance on error status");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rsp_pkg::ST_OK |->
      out_range_mm >= rsp_pkg::MIN_MM[rsp_pkg::DIST_W-1:0] &&
      out_range_mm <= rsp_pkg::MAX_MM[rsp_pkg::DIST_W-1:0])
    else $error("ok result out of range");

  // start never produces a result
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && in_command == rsp_pkg::CMD_START |=> !out_valid)
    else $error("result after start item");

  // backpressure only with a pending result
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind ranging_sensor_packet_parser_core rsp_checker u_rsp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_command   (in_command),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_range_mm (out_range_mm),
  .out_status   (out_status)
);

FILE: bench/tb_ranging_sensor_packet_parser_core.sv
module tb_ranging_sensor_packet_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rsp_pkg::*;

  localparam int CLK_PERIOD = 10;
  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT = 5000;
  // no package name for the fourth command code, the parser ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // wait_ticks register byte address
  localparam logic [ADDR_W-1:0] WAIT_TICKS_ADDR = {REG_WAIT_TICKS, 2'b00};
  // useful items per random phase, eight phases
  localparam int PHASE_ITEMS = 182;

  typedef enum logic [1:0] {PARSE_IDLE, PARSE_HUNT, PARSE_COLLECT} parse_phase_t;

  // frame parser mirror plus the queue of results still owed by the block
  class range_scoreboard;
    logic [15:0]  wait_ticks;
    parse_phase_t phase;
    logic [1:0]   bytes_taken;
    logic [15:0]  elapsed;
    logic [7:0]   dist_hi;
    logic [7:0]   dist_lo;
    result_t      owed_q[$];
    int           errors;
    int           items_taken;
    int           useful_items;
    int           status_count[5];

    function new();
      wait_ticks   = WAIT_TICKS_RESET;
      phase        = PARSE_IDLE;
      bytes_taken  = '0;
      elapsed      = '0;
      dist_hi      = '0;
      dist_lo      = '0;
      errors       = 0;
      items_taken  = 0;
      useful_items = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_wait(logic [15:0] value);
      wait_ticks = value;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void close_measurement(logic [DIST_W-1:0] mm, logic [STAT_W-1:0] st);
      result_t r;
      r.range_mm = mm;
      r.status   = st;
      owed_q.push_back(r);
      phase       = PARSE_IDLE;
      bytes_taken = '0;
      elapsed     = '0;
    endfunction

    // one accepted input item
    function void note_item(logic [1:0] cmd, logic [7:0] data);
      logic [16:0] next_count;
      logic [7:0]  sum;
      logic [15:0] frame_mm;
      items_taken++;
      if (cmd == CMD_START) begin
        // also abandons a measurement in progress, silently
        useful_items++;
        phase       = PARSE_HUNT;
        bytes_taken = '0;
        elapsed     = '0;
        return;
      end
      if (phase == PARSE_IDLE) return;
      if (cmd == CMD_TICK) begin
        useful_items++;
        next_count = {1'b0, elapsed} + 17'd1;
        if (next_count >= {1'b0, wait_ticks}) begin
          close_measurement('0, (phase == PARSE_HUNT) ? ST_HDR_TIMEOUT : ST_INCOMPLETE);
        end else begin
          elapsed = next_count[15:0];
        end
        return;
      end
      if (cmd != CMD_BYTE) return;
      useful_items++;
      if (phase == PARSE_HUNT) begin
        if (data == HDR_BYTE) begin
          phase       = PARSE_COLLECT;
          bytes_taken = '0;
          elapsed     = '0;
        end
        return;
      end
      case (bytes_taken)
        2'd0: begin
          dist_hi     = data;
          bytes_taken = 2'd1;
        end
        2'd1: begin
          dist_lo     = data;
          bytes_taken = 2'd2;
        end
        default: begin
          sum      = HDR_BYTE + dist_hi + dist_lo;
          frame_mm = {dist_hi, dist_lo};
          if (sum != data) begin
            close_measurement('0, ST_CSUM_ERR);
          end else if (frame_mm < MIN_MM || frame_mm > MAX_MM) begin
            close_measurement('0, ST_RANGE_ERR);
          end else begin
            close_measurement(frame_mm[DIST_W-1:0], ST_OK);
          end
        end
      endcase
    endfunction

    // one accepted result against the oldest owed one
    function void check_result(logic [DIST_W-1:0] mm, logic [STAT_W-1:0] st);
      result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got distance %0d status %0d",
                 $time, mm, st);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (want.status <= ST_RANGE_ERR) status_count[want.status]++;
      if (mm !== want.range_mm) begin
        $display("%0t: range_mm mismatch, expected %0d, got %0d",
                 $time, want.range_mm, mm);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [1:0]           in_command = CMD_TICK;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_ready  = 1'b0;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [ADDR_W-1:0]    paddr      = '0;
  logic [31:0]          pwdata     = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic [DIST_W-1:0]    out_range_mm;
  logic [STAT_W-1:0]    out_status;
  logic [31:0]          prdata;
  logic                 pready;

  range_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  logic [15:0] cur_wait = WAIT_TICKS_RESET;
  int wait_plan[8] = '{7, 100, 3, 1, 40, 65535, 2, 12};

  always #(CLK_PERIOD / 2) clk = ~clk;

  ranging_sensor_packet_parser_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_range_mm (out_range_mm),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (recv_stall_pct == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // handshake monitor: sees pre-edge values, result first since it was caused earlier
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_range_mm, out_status);
      if (in_valid && in_ready) sb.note_item(in_command, in_rx_byte);
      if ((out_valid && out_ready) || (in_valid && in_ready) || psel) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // hang guard
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles, %0d results still owed",
             $time, QUIET_LIMIT, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item, random idle cycles first, valid left high once taken
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait out every owed result plus the output latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one apb transfer: setup then access, pready is tied high
  task automatic cfg_access(input logic wr, input logic [15:0] value,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WAIT_TICKS_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_wait_reg(input logic [15:0] want);
    logic [31:0] rd;
    cfg_access(1'b0, 16'h0000, rd);
    if (rd[15:0] !== want) begin
      $display("%0t: wait_ticks readback mismatch, expected %0d, got %0d",
               $time, want, rd[15:0]);
      sb.errors++;
    end
  endtask

  // register written only with the parser quiet
  task automatic write_wait(input logic [15:0] value);
    logic [31:0] rd;
    drain();
    cfg_access(1'b1, value, rd);
    sb.set_wait(value);
    cur_wait = value;
    check_wait_reg(value);
  endtask

  // a tick or an ignored code now and then between frame bytes
  task automatic maybe_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) begin
      send_item(CMD_TICK, 8'($urandom));
    end else if (roll < 24) begin
      send_item(CMD_UNUSED, 8'($urandom));
    end
  endtask

  // one random measurement, mostly well formed with random content
  task automatic send_frame();
    int kind;
    logic [15:0] frame_mm;
    logic [7:0]  csum;
    kind = $urandom_range(99);
    // full timeouts only where the tick count stays sane
    if (kind >= 80 && kind < 88 && cur_wait > 200) kind = 70;

    // idle traffic, which the parser drops unless a measurement is still open
    if ($urandom_range(19) == 0) send_item(2'($urandom_range(1, 3)), 8'($urandom));

    send_item(CMD_START, 8'($urandom));
    // noise while hunting, never the header value
    repeat ($urandom_range(0, 2)) begin
      send_item(CMD_BYTE, 8'($urandom_range(0, 254)));
      maybe_gap();
    end

    if (kind >= 80 && kind < 85) begin
      // hunt timeout
      repeat (int'(cur_wait) + 1) send_item(CMD_TICK, 8'($urandom));
      return;
    end

    send_item(CMD_BYTE, HDR_BYTE);
    maybe_gap();

    if (kind >= 85 && kind < 88) begin
      // collection timeout, possibly after a partial frame
      repeat ($urandom_range(0, 2)) send_item(CMD_BYTE, 8'($urandom));
      repeat (int'(cur_wait) + 1) send_item(CMD_TICK, 8'($urandom));
      return;
    end
    if (kind >= 88 && kind < 94) begin
      // partial frame, the next start abandons it
      repeat ($urandom_range(0, 2)) send_item(CMD_BYTE, 8'($urandom));
      return;
    end

    if (kind >= 60 && kind < 70) begin
      // around and beyond the range limits
      case ($urandom_range(5))
        0:       frame_mm = 16'd29;
        1:       frame_mm = 16'd30;
        2:       frame_mm = 16'd4500;
        3:       frame_mm = 16'd4501;
        4:       frame_mm = 16'($urandom_range(0, 29));
        default: frame_mm = 16'($urandom_range(4501, 65535));
      endcase
    end else begin
      frame_mm = 16'($urandom_range(30, 4500));
    end
    csum = HDR_BYTE + frame_mm[15:8] + frame_mm[7:0];
    if (kind >= 70 && kind < 80) csum = csum ^ 8'($urandom_range(1, 255));

    send_item(CMD_BYTE, frame_mm[15:8]);
    maybe_gap();
    send_item(CMD_BYTE, frame_mm[7:0]);
    maybe_gap();
    send_item(CMD_BYTE, csum);
  endtask

  initial begin
    int target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the register
    check_wait_reg(WAIT_TICKS_RESET);

    // idle traffic and the unused code, no result
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_UNUSED, 8'h5A);
    // shortest legal distance
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h1E);
    send_item(CMD_BYTE, 8'h1D);
    // longest legal distance
    send_item(CMD_START, 8'hFF);
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_BYTE, 8'h11);
    send_item(CMD_BYTE, 8'h94);
    send_item(CMD_BYTE, 8'hA4);
    // all-ones bytes, checksum good but distance out of range
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFD);
    // bad checksum wins over bad range
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h1D);
    send_item(CMD_BYTE, 8'h00);

    // restart while collecting, then hunt timeout
    write_wait(16'd2);
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_START, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    // collection timeout, tick count restarts at the header
    send_item(CMD_START, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, HDR_BYTE);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);

    // zero wait, the first tick times out
    write_wait(16'd0);
    send_item(CMD_START, 8'h00);
    send_item(CMD_TICK, 8'h00);

    // full-width wait, a run of ticks stays well short of the timeout
    write_wait(16'hFFFF);
    send_item(CMD_START, 8'h00);
    repeat (40) send_item(CMD_TICK, 8'($urandom));

    // random frames: four pacing mixes, two wait settings in each
    wait_plan[7] = $urandom_range(4, 60);
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 2; k++) begin
        write_wait(16'(wait_plan[2 * m + k]));
        case (m)
          0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct  = 76;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 76;
          end
          default: begin
            send_idle_pct  = 17;
            recv_stall_pct = 17;
          end
        endcase
        target = sb.useful_items + PHASE_ITEMS;
        while (sb.useful_items < target) send_frame();
      end
    end

    drain();
    $display("run covered %0d items (%0d acted on), wait_ticks from 0 to 65535, four pacings",
             sb.items_taken, sb.useful_items);
    $display("results: %0d ok, %0d header timeout, %0d incomplete, %0d checksum, %0d range",
             sb.status_count[0], sb.status_count[1], sb.status_count[2],
             sb.status_count[3], sb.status_count[4]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: ranging_sensor_packet_parser_core.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_frame_fsm.sv
hw/rtl/rsp_out_buf.sv
hw/rtl/ranging_sensor_packet_parser_core.sv
hw/rtl/rsp_checker.sv
bench/tb_ranging_sensor_packet_parser_core.sv
